[hw/rtl/gat_pkg.sv]
// Shared types and constants for the geometric admissibility test.
package gat_pkg;

   localparam int COORD_W      = 32;
   localparam int FACTOR_W     = 16;
   localparam int DIMS_CFG_W   = 3;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 16;
   localparam int COUNT_W      = 2;
   localparam int QUEUE_DEPTH  = 2;

   localparam logic [COUNT_W-1:0] COUNT_SAT = 2'd2;

   localparam int PAD_VALUE    = 65536;
   localparam int RHS_SHIFT    = 14;

   localparam int EXT_W        = COORD_W + 2;
   localparam int DIAM_W       = COORD_W + 1;
   localparam int CHUNK_W      = 17;
   localparam int MUL_A_W      = DIAM_W + FACTOR_W;
   localparam int PROD_W       = MUL_A_W + CHUNK_W;
   localparam int OP_W         = 4 * CHUNK_W;
   localparam int LHS_W        = 2 * MUL_A_W;
   localparam int CHUNK_IDX_W  = 2;

   localparam int SQ_LAST_CHUNK = (DIAM_W + CHUNK_W - 1) / CHUNK_W - 1;
   localparam int AD_LAST_CHUNK = (MUL_A_W + CHUNK_W - 1) / CHUNK_W - 1;

   localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

   localparam logic [FACTOR_W-1:0]   FACTOR_RESET = 16'd256;
   localparam logic [DIMS_CFG_W-1:0] DIMS_RESET   = 3'd2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ADMIS_FACTOR = 2'd0,
      CSR_DIMS_IN_USE  = 2'd1
   } csr_index_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_SQ_MUL,
      BK_SQ_ACC,
      BK_AD_MUL,
      BK_AD_ACC,
      BK_ADSQ_MUL,
      BK_ADSQ_ACC,
      BK_DECIDE
   } back_state_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

endpackage

[hw/rtl/gat_fifo.sv]
// Small register FIFO used between the front, the back and the result port.
module gat_fifo
   import gat_pkg::*;
#(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output fifo_status_type  status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_data     = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[hw/rtl/gat_front.sv]
// Front: per-side bounding boxes and point counts, snapshot on the last coordinate.
module gat_front
   import gat_pkg::*;
#(
   parameter int MAX_DIMS = 4
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_push,
   input  logic                                  req_point_side,
   input  logic [1:0]                            req_dim_index,
   input  logic signed [COORD_W-1:0]             req_coord_value,
   input  logic                                  req_last_coord,
   input  logic [DIMS_CFG_W-1:0]                 n_dims,
   input  fifo_status_type                       q_status,
   output logic                                  q_push,
   output logic [4*MAX_DIMS*COORD_W:0]           q_data
);

   localparam int SEG = MAX_DIMS * COORD_W;

   logic signed [COORD_W-1:0] row_min_ff [MAX_DIMS];
   logic signed [COORD_W-1:0] row_max_ff [MAX_DIMS];
   logic signed [COORD_W-1:0] col_min_ff [MAX_DIMS];
   logic signed [COORD_W-1:0] col_max_ff [MAX_DIMS];
   logic signed [COORD_W-1:0] row_min_in [MAX_DIMS];
   logic signed [COORD_W-1:0] row_max_in [MAX_DIMS];
   logic signed [COORD_W-1:0] col_min_in [MAX_DIMS];
   logic signed [COORD_W-1:0] col_max_in [MAX_DIMS];
   logic signed [COORD_W-1:0] row_min_upd [MAX_DIMS];
   logic signed [COORD_W-1:0] row_max_upd [MAX_DIMS];
   logic signed [COORD_W-1:0] col_min_upd [MAX_DIMS];
   logic signed [COORD_W-1:0] col_max_upd [MAX_DIMS];
   logic [COUNT_W-1:0]        row_cnt_ff, row_cnt_in, row_cnt_upd;
   logic [COUNT_W-1:0]        col_cnt_ff, col_cnt_in, col_cnt_upd;
   logic                      accept;
   logic                      hit;

   assign accept = req_push && !q_status.full;
   assign q_push = accept && req_last_coord;

   always_comb begin
      hit         = 1'b0;
      row_cnt_upd = row_cnt_ff;
      col_cnt_upd = col_cnt_ff;
      if (accept && req_dim_index == 2'd0) begin
         if (!req_point_side) begin
            if (row_cnt_ff != COUNT_SAT) row_cnt_upd = row_cnt_ff + 1'b1;
         end else begin
            if (col_cnt_ff != COUNT_SAT) col_cnt_upd = col_cnt_ff + 1'b1;
         end
      end
      for (int d = 0; d < MAX_DIMS; d++) begin
         row_min_upd[d] = row_min_ff[d];
         row_max_upd[d] = row_max_ff[d];
         col_min_upd[d] = col_min_ff[d];
         col_max_upd[d] = col_max_ff[d];
         hit = accept && (4'(req_dim_index) == 4'(d)) && (4'(d) < 4'(n_dims));
         if (hit && !req_point_side) begin
            if (req_coord_value < row_min_ff[d]) row_min_upd[d] = req_coord_value;
            if (req_coord_value > row_max_ff[d]) row_max_upd[d] = req_coord_value;
         end
         if (hit && req_point_side) begin
            if (req_coord_value < col_min_ff[d]) col_min_upd[d] = req_coord_value;
            if (req_coord_value > col_max_ff[d]) col_max_upd[d] = req_coord_value;
         end
         q_data[0*SEG + d*COORD_W +: COORD_W] = row_min_upd[d];
         q_data[1*SEG + d*COORD_W +: COORD_W] = row_max_upd[d];
         q_data[2*SEG + d*COORD_W +: COORD_W] = col_min_upd[d];
         q_data[3*SEG + d*COORD_W +: COORD_W] = col_max_upd[d];
         if (q_push) begin
            row_min_in[d] = COORD_MAX;
            row_max_in[d] = COORD_MIN;
            col_min_in[d] = COORD_MAX;
            col_max_in[d] = COORD_MIN;
         end else begin
            row_min_in[d] = row_min_upd[d];
            row_max_in[d] = row_max_upd[d];
            col_min_in[d] = col_min_upd[d];
            col_max_in[d] = col_max_upd[d];
         end
      end
      q_data[4*SEG] = (row_cnt_upd == COUNT_SAT) && (col_cnt_upd == COUNT_SAT);
      row_cnt_in    = q_push ? '0 : row_cnt_upd;
      col_cnt_in    = q_push ? '0 : col_cnt_upd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int d = 0; d < MAX_DIMS; d++) begin
            row_min_ff[d] <= COORD_MAX;
            row_max_ff[d] <= COORD_MIN;
            col_min_ff[d] <= COORD_MAX;
            col_max_ff[d] <= COORD_MIN;
         end
         row_cnt_ff <= '0;
         col_cnt_ff <= '0;
      end else begin
         for (int d = 0; d < MAX_DIMS; d++) begin
            row_min_ff[d] <= row_min_in[d];
            row_max_ff[d] <= row_max_in[d];
            col_min_ff[d] <= col_min_in[d];
            col_max_ff[d] <= col_max_in[d];
         end
         row_cnt_ff <= row_cnt_in;
         col_cnt_ff <= col_cnt_in;
      end
   end

endmodule

[hw/rtl/gat_back.sv]
// Back: diameter, squared centre distance and the admissibility compare.
module gat_back
   import gat_pkg::*;
#(
   parameter int MAX_DIMS = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [4*MAX_DIMS*COORD_W:0] q_data,
   input  fifo_status_type             q_status,
   output logic                        q_pop,
   input  logic [FACTOR_W-1:0]         admis_factor,
   input  logic [DIMS_CFG_W-1:0]       n_dims,
   input  fifo_status_type             r_status,
   output logic                        r_push,
   output logic                        r_data
);

   localparam int SEG       = MAX_DIMS * COORD_W;
   localparam int DIM_IDX_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

   back_state_type              state_ff, state_in;
   logic [DIM_IDX_W-1:0]        d_ff, d_in;
   logic [CHUNK_IDX_W-1:0]      k_ff, k_in;
   logic [DIAM_W-1:0]           diam_ff, diam_in, diam_dim;
   logic [LHS_W-1:0]            sum_ff, sum_in;
   logic [LHS_W-1:0]            lhs_ff, lhs_in;
   logic [MUL_A_W-1:0]          ad_ff, ad_in;
   logic [PROD_W-1:0]           prod_ff, prod_in;
   logic [MUL_A_W-1:0]          mul_a;
   logic [CHUNK_W-1:0]          mul_b;
   logic [OP_W-1:0]             op_pad;
   logic [LHS_W-1:0]            term;
   logic signed [COORD_W-1:0]   rmin, rmax, cmin, cmax;
   logic signed [EXT_W-1:0]     er, ec, s, s_abs;
   logic signed [EXT_W:0]       diam_s;
   logic [DIAM_W-1:0]           mag;
   logic                        last_dim;

   assign rmin = q_data[0*SEG + int'(d_ff)*COORD_W +: COORD_W];
   assign rmax = q_data[1*SEG + int'(d_ff)*COORD_W +: COORD_W];
   assign cmin = q_data[2*SEG + int'(d_ff)*COORD_W +: COORD_W];
   assign cmax = q_data[3*SEG + int'(d_ff)*COORD_W +: COORD_W];

   assign er     = EXT_W'(rmax) - EXT_W'(rmin) + EXT_W'(PAD_VALUE);
   assign ec     = EXT_W'(cmax) - EXT_W'(cmin) + EXT_W'(PAD_VALUE);
   assign s      = (EXT_W'(rmin) + EXT_W'(rmax)) - (EXT_W'(cmin) + EXT_W'(cmax));
   assign s_abs  = s[EXT_W-1] ? -s : s;
   assign mag    = s_abs[DIAM_W-1:0];
   assign diam_s = $signed({2'b00, diam_ff});

   always_comb begin
      diam_dim = diam_ff;
      if ((EXT_W+1)'(er) > diam_s) diam_dim = er[DIAM_W-1:0];
      if ((EXT_W+1)'(ec) > diam_s && ec > er) diam_dim = ec[DIAM_W-1:0];
      if ((EXT_W+1)'(ec) > diam_s && (EXT_W+1)'(er) <= diam_s) diam_dim = ec[DIAM_W-1:0];
   end

   assign last_dim = (4'(d_ff) + 4'd1 == 4'(n_dims));
   assign term     = LHS_W'(prod_ff) << (k_ff * CHUNK_W);

   always_comb begin
      state_in = state_ff;
      d_in     = d_ff;
      k_in     = k_ff;
      diam_in  = diam_ff;
      sum_in   = sum_ff;
      lhs_in   = lhs_ff;
      ad_in    = ad_ff;
      q_pop    = 1'b0;
      r_push   = 1'b0;
      r_data   = 1'b0;
      mul_a    = '0;
      op_pad   = '0;
      case (state_ff)
         BK_IDLE: begin
            if (!q_status.empty) begin
               d_in     = '0;
               k_in     = '0;
               diam_in  = '0;
               sum_in   = '0;
               lhs_in   = '0;
               state_in = BK_SQ_MUL;
            end
         end
         BK_SQ_MUL: begin
            mul_a  = MUL_A_W'(mag);
            op_pad = OP_W'(mag);
            if (k_ff == '0) diam_in = diam_dim;
            state_in = BK_SQ_ACC;
         end
         BK_SQ_ACC: begin
            sum_in = sum_ff + term;
            if (k_ff == CHUNK_IDX_W'(SQ_LAST_CHUNK)) begin
               k_in = '0;
               if (last_dim) begin
                  state_in = BK_AD_MUL;
               end else begin
                  d_in     = d_ff + 1'b1;
                  state_in = BK_SQ_MUL;
               end
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = BK_SQ_MUL;
            end
         end
         BK_AD_MUL: begin
            mul_a    = MUL_A_W'(diam_ff);
            op_pad   = OP_W'(admis_factor);
            state_in = BK_AD_ACC;
         end
         BK_AD_ACC: begin
            ad_in    = prod_ff[MUL_A_W-1:0];
            state_in = BK_ADSQ_MUL;
         end
         BK_ADSQ_MUL: begin
            mul_a    = ad_ff;
            op_pad   = OP_W'(ad_ff);
            state_in = BK_ADSQ_ACC;
         end
         BK_ADSQ_ACC: begin
            lhs_in = lhs_ff + term;
            if (k_ff == CHUNK_IDX_W'(AD_LAST_CHUNK)) begin
               k_in     = '0;
               state_in = BK_DECIDE;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = BK_ADSQ_MUL;
            end
         end
         BK_DECIDE: begin
            if (!r_status.full) begin
               r_push   = 1'b1;
               q_pop    = 1'b1;
               r_data   = q_data[4*SEG] && (lhs_ff < (sum_ff << RHS_SHIFT));
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
      mul_b   = op_pad[k_ff*CHUNK_W +: CHUNK_W];
      prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         d_ff     <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         d_ff     <= d_in;
         k_ff     <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      diam_ff <= diam_in;
      sum_ff  <= sum_in;
      lhs_ff  <= lhs_in;
      ad_ff   <= ad_in;
      prod_ff <= prod_in;
   end

   a_dim_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_SQ_MUL || state_ff == BK_SQ_ACC) |-> (4'(d_ff) < 4'(n_dims)))
      else $error("dimension counter past the dimensions in use");

   a_chunk_in_range: assert property (@(posedge clock) disable iff (reset)
      k_ff <= CHUNK_IDX_W'(AD_LAST_CHUNK))
      else $error("chunk counter out of range");

   a_start_needs_entry: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_IDLE && state_in != BK_IDLE) |-> !q_status.empty)
      else $error("test started without a queued box");

   a_done_returns_idle: assert property (@(posedge clock) disable iff (reset)
      r_push |=> (state_ff == BK_IDLE && k_ff == '0))
      else $error("sequencer not idle after result");

endmodule

[hw/rtl/geometric_admissibility_test.sv]
// Top level of the geometric admissibility test for one H-matrix block pair.
// Coordinates are taken one per cycle while req_full is low; the front folds
// each into per-side bounding boxes and, on the last coordinate, queues a
// snapshot (two deep) and clears for the next pair. The back runs the test on
// one shared 49x17 multiplier, with a multiply state and an accumulate state
// per 17-bit chunk; req_full rises while both snapshot slots wait. One result
// transaction per last coordinate.
module geometric_admissibility_test
   import gat_pkg::*;
#(
   parameter int MAX_DIMS = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   output logic                      req_full,
   input  logic                      req_point_side,
   input  logic [1:0]                req_dim_index,
   input  logic signed [COORD_W-1:0] req_coord_value,
   input  logic                      req_last_coord,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output logic                      rsp_admissible,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_wdata
);

   localparam int ENTRY_W = 4 * MAX_DIMS * COORD_W + 1;

   logic [FACTOR_W-1:0]   admis_factor_ff, admis_factor_in;
   logic [DIMS_CFG_W-1:0] dims_in_use_ff, dims_in_use_in;
   logic [DIMS_CFG_W-1:0] n_dims;
   logic                  q_push, q_pop, r_push, r_data;
   logic [ENTRY_W-1:0]    q_wdata, q_rdata;
   fifo_status_type       q_status, r_status;

   assign csr_ready = 1'b1;

   always_comb begin
      admis_factor_in = admis_factor_ff;
      dims_in_use_in  = dims_in_use_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_ADMIS_FACTOR: admis_factor_in = csr_wdata[FACTOR_W-1:0];
            CSR_DIMS_IN_USE:  dims_in_use_in  = csr_wdata[DIMS_CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         admis_factor_ff <= FACTOR_RESET;
         dims_in_use_ff  <= DIMS_RESET;
      end else begin
         admis_factor_ff <= admis_factor_in;
         dims_in_use_ff  <= dims_in_use_in;
      end
   end

   always_comb begin
      if (dims_in_use_ff == '0) begin
         n_dims = DIMS_CFG_W'(1);
      end else if (32'(dims_in_use_ff) > MAX_DIMS) begin
         n_dims = DIMS_CFG_W'(MAX_DIMS);
      end else begin
         n_dims = dims_in_use_ff;
      end
   end

   assign req_full  = q_status.full;
   assign rsp_empty = r_status.empty;

   gat_front #(.MAX_DIMS(MAX_DIMS)) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_point_side  (req_point_side),
      .req_dim_index   (req_dim_index),
      .req_coord_value (req_coord_value),
      .req_last_coord  (req_last_coord),
      .n_dims          (n_dims),
      .q_status        (q_status),
      .q_push          (q_push),
      .q_data          (q_wdata)
   );

   gat_fifo #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_box_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .pop       (q_pop),
      .pop_data  (q_rdata),
      .status    (q_status)
   );

   gat_back #(.MAX_DIMS(MAX_DIMS)) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_data       (q_rdata),
      .q_status     (q_status),
      .q_pop        (q_pop),
      .admis_factor (admis_factor_ff),
      .n_dims       (n_dims),
      .r_status     (r_status),
      .r_push       (r_push),
      .r_data       (r_data)
   );

   gat_fifo #(.WIDTH(1), .DEPTH(QUEUE_DEPTH)) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (r_push),
      .push_data (r_data),
      .pop       (rsp_pop),
      .pop_data  (rsp_admissible),
      .status    (r_status)
   );

endmodule
